/* sv/sim_pkg.sv */
// Shared types and constants for the sorted index merge table.
// Used by sim_table_mem, sim_ctrl and sorted_index_merge_table.
package sim_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int CFG_IDX_W           = 2;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_MERGE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RELOCATION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES    = 2'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] entry_id;
        logic [31:0] entry_offset;
        logic [31:0] entry_size;
        logic [31:0] entry_packed_size;
        logic [9:0]  read_position;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        replaced;
        logic [9:0]  hit_position;
        logic [31:0] out_id;
        logic [31:0] out_offset;
        logic [31:0] out_size;
        logic [31:0] out_packed_size;
        logic [10:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] offset;
        logic [31:0] size;
        logic [31:0] packed_size;
    } t_entry;

    typedef struct packed {
        logic [31:0] relocation_base;
        logic [15:0] header_bytes;
    } t_cfg;

endpackage

/* sv/sorted_index_merge_table.sv */
// Sorted index merge table: holds id-ordered archive index entries.
// Operations: append, merge (insert or replace), lookup by id, read by position.
// Input transaction: i_in_valid / o_in_ready carrying t_in.
// Result transaction: o_out_valid / i_out_ready carrying t_out, one per input.
// Config transaction: i_cfg_valid / o_cfg_ready, index 0 relocation base,
// index 1 header bytes (low 16 bits of data); other indexes are ignored.
// Write config only while no operation is in flight.
// One operation at a time, all table access through the table memory
// (one read port, one write port, registered read data). Steps from
// accept until the result is registered and the input is ready again:
//   append writes the entry (none when full); read reads one entry (none when out of range);
//   lookup reads and compares one entry per probe of a binary search
//   (up to floor(log2(count))+1 probes);
//   merge scans entries in order (read, compare) and replaces on an equal id, else
//   decides insert or full, shifts entries up (read, write) and inserts.
// The result register frees the input side while a result waits; a stalled
// receiver holds the next finished operation until the register drains.
// Reset clears the entry count and config registers; table contents are not
// cleared, entries become defined as they are written. No clearing pass.
module sorted_index_merge_table
    import sim_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW         = $clog2(TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cfg          r_cfg;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RELOCATION_BASE: r_cfg.relocation_base <= i_cfg_data;
                CFG_HEADER_BYTES:    r_cfg.header_bytes    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    sim_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    sim_table_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

/* sv/sim_table_mem.sv */
// Entry table storage: one write port, one read port, registered read data.
// Depends on sim_pkg for the entry type.
module sim_table_mem
    import sim_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/sim_ctrl.sv */
// Operation sequencer: linear merge scan, shift-up insert, binary search,
// positional read, and the result register. Depends on sim_pkg.
module sim_ctrl
    import sim_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in           i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out          o_out_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_entry        i_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_entry        o_wr_data
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SCAN_RD  = 11'b00000000010,
        S_SCAN_CMP = 11'b00000000100,
        S_DECIDE   = 11'b00000001000,
        S_SHIFT_RD = 11'b00000010000,
        S_SHIFT_WR = 11'b00000100000,
        S_INS      = 11'b00001000000,
        S_BS_RD    = 11'b00010000000,
        S_BS_CMP   = 11'b00100000000,
        S_RD_WAIT  = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } t_state;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state        r_state,     n_state;
    logic [CW-1:0] r_count,     n_count;
    t_in           r_cur,       n_cur;
    logic [31:0]   r_reloc,     n_reloc;
    logic [CW-1:0] r_j,         n_j;
    logic [AW-1:0] r_k,         n_k;
    logic [CW-1:0] r_lo,        n_lo;
    logic [CW-1:0] r_hx,        n_hx;
    logic [AW-1:0] r_mid,       n_mid;
    logic [1:0]    r_status,    n_status;
    logic          r_replaced,  n_replaced;
    logic [AW-1:0] r_pos,       n_pos;
    t_entry        r_ent,       n_ent;
    logic          r_out_valid, n_out_valid;
    t_out          r_out,       n_out;

    logic [CW-1:0]    w_span;
    logic [CW-1:0]    w_mid;
    logic [CW+9:0]    w_rpos_wide;
    logic [CW+9:0]    w_cnt_cmp;
    logic [AW+9:0]    w_rpos_addr;
    logic [AW+9:0]    w_pos_wide;
    logic [CW+10:0]   w_cnt_wide;
    t_entry           w_new_ent;
    t_out             w_fin;

    assign w_span      = r_hx - r_lo - CW'(1);
    assign w_mid       = r_lo + (w_span >> 1);
    assign w_rpos_wide = {{CW{1'b0}}, i_in_data.read_position};
    assign w_cnt_cmp   = {10'b0, r_count};
    assign w_rpos_addr = {{AW{1'b0}}, i_in_data.read_position};
    assign w_pos_wide  = {10'b0, r_pos};
    assign w_cnt_wide  = {11'b0, r_count};

    assign w_new_ent.id          = r_cur.entry_id;
    assign w_new_ent.offset      = r_reloc;
    assign w_new_ent.size        = r_cur.entry_size;
    assign w_new_ent.packed_size = r_cur.entry_packed_size;

    always_comb begin
        w_fin.status          = r_status;
        w_fin.replaced        = r_replaced;
        w_fin.hit_position    = w_pos_wide[9:0];
        w_fin.out_id          = r_ent.id;
        w_fin.out_offset      = r_ent.offset;
        w_fin.out_size        = r_ent.size;
        w_fin.out_packed_size = r_ent.packed_size;
        w_fin.entry_count     = w_cnt_wide[10:0];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_reloc     = r_reloc;
        n_j         = r_j;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hx        = r_hx;
        n_mid       = r_mid;
        n_status    = r_status;
        n_replaced  = r_replaced;
        n_pos       = r_pos;
        n_ent       = r_ent;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur      = i_in_data;
                    n_reloc    = i_cfg.relocation_base + i_in_data.entry_offset
                               - {16'b0, i_cfg.header_bytes};
                    n_status   = ST_OK;
                    n_replaced = 1'b0;
                    n_pos      = '0;
                    n_ent      = '0;
                    n_j        = '0;
                    n_lo       = '0;
                    n_hx       = r_count;
                    case (i_in_data.operation)
                        OP_APPEND: begin
                            n_state = S_FIN;
                            if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                o_wr_en                 = 1'b1;
                                o_wr_addr               = r_count[AW-1:0];
                                o_wr_data.id            = i_in_data.entry_id;
                                o_wr_data.offset        = i_in_data.entry_offset;
                                o_wr_data.size          = i_in_data.entry_size;
                                o_wr_data.packed_size   = i_in_data.entry_packed_size;
                                n_ent                   = o_wr_data;
                                n_pos                   = r_count[AW-1:0];
                                n_count                 = r_count + CW'(1);
                            end
                        end
                        OP_MERGE: begin
                            n_state = S_SCAN_RD;
                        end
                        OP_LOOKUP: begin
                            n_state = S_BS_RD;
                        end
                        default: begin
                            if (w_rpos_wide >= w_cnt_cmp) begin
                                n_status = ST_BAD_POS;
                                n_state  = S_FIN;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_rpos_addr[AW-1:0];
                                n_pos     = w_rpos_addr[AW-1:0];
                                n_state   = S_RD_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_j == r_count) begin
                    n_state = S_DECIDE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_j[AW-1:0];
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_rd_data.id < r_cur.entry_id) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_SCAN_RD;
                end else if (i_rd_data.id == r_cur.entry_id) begin
                    o_wr_en    = 1'b1;
                    o_wr_addr  = r_j[AW-1:0];
                    o_wr_data  = w_new_ent;
                    n_ent      = w_new_ent;
                    n_pos      = r_j[AW-1:0];
                    n_replaced = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else if (r_j == r_count) begin
                    n_state = S_INS;
                end else begin
                    n_k     = r_count[AW-1:0] - AW'(1);
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_k;
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_k + AW'(1);
                o_wr_data = i_rd_data;
                if (r_k == r_j[AW-1:0]) begin
                    n_state = S_INS;
                end else begin
                    n_k     = r_k - AW'(1);
                    n_state = S_SHIFT_RD;
                end
            end
            S_INS: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_j[AW-1:0];
                o_wr_data = w_new_ent;
                n_ent     = w_new_ent;
                n_pos     = r_j[AW-1:0];
                n_count   = r_count + CW'(1);
                n_state   = S_FIN;
            end
            S_BS_RD: begin
                if (r_lo >= r_hx) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_mid[AW-1:0];
                    n_mid     = w_mid[AW-1:0];
                    n_state   = S_BS_CMP;
                end
            end
            S_BS_CMP: begin
                if (i_rd_data.id == r_cur.entry_id) begin
                    n_ent   = i_rd_data;
                    n_pos   = r_mid;
                    n_state = S_FIN;
                end else if (r_cur.entry_id < i_rd_data.id) begin
                    n_hx    = {{(CW-AW){1'b0}}, r_mid};
                    n_state = S_BS_RD;
                end else begin
                    n_lo    = {{(CW-AW){1'b0}}, r_mid} + CW'(1);
                    n_state = S_BS_RD;
                end
            end
            S_RD_WAIT: begin
                n_ent   = i_rd_data;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = w_fin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_reloc    <= n_reloc;
        r_j        <= n_j;
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_hx       <= n_hx;
        r_mid      <= n_mid;
        r_status   <= n_status;
        r_replaced <= n_replaced;
        r_pos      <= n_pos;
        r_ent      <= n_ent;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sim/sorted_index_merge_table_tb.sv */
// Self-checking testbench for sorted_index_merge_table: directed and random table operations
// against a behavioral copy of the sorted index table, with random stalls on both channels.
// Depends on sim_pkg and the sorted_index_merge_table RTL.
`timescale 1ns / 1ps

module sorted_index_merge_table_tb
    import sim_pkg::*;
();

    localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 290;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd2;

    class merge_table_scoreboard;
        t_entry      rows [DEPTH];
        int          count;
        logic [31:0] reloc_base;
        logic [15:0] hdr_bytes;
        t_out        expected_results [$];
        int          errors;
        int          results_seen;
        int          replace_hits;
        int          op_hits [4];
        int          status_hits [4];

        function new();
            count        = 0;
            reloc_base   = '0;
            hdr_bytes    = '0;
            errors       = 0;
            results_seen = 0;
            replace_hits = 0;
            for (int k = 0; k < 4; k++) begin
                op_hits[k]     = 0;
                status_hits[k] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_RELOCATION_BASE: reloc_base = data;
                CFG_HEADER_BYTES:    hdr_bytes  = data[15:0];
                default: ;
            endcase
        endfunction

        function bit holds_id(logic [31:0] id);
            for (int k = 0; k < count; k++) begin
                if (rows[k].id == id) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Applies one operation to the table copy and returns the result it must produce.
        function t_out apply_table_op(t_in req);
            t_out        res;
            t_entry      row;
            logic [31:0] reloc;
            int          pos;
            int          lo;
            int          hi;
            int          mid;
            int          k;
            bit          hit;
            res = '0;
            hit = 1'b0;
            pos = 0;
            row = '{id: req.entry_id, offset: req.entry_offset, size: req.entry_size,
                    packed_size: req.entry_packed_size};
            op_hits[req.operation]++;
            case (req.operation)
                OP_APPEND: begin
                    if (count >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        rows[count] = row;
                        pos = count;
                        count++;
                        hit = 1'b1;
                    end
                end
                OP_MERGE: begin
                    reloc = reloc_base + req.entry_offset - {16'h0000, hdr_bytes};
                    row.offset = reloc;
                    while (pos < count && rows[pos].id < req.entry_id) pos++;
                    if (pos < count && rows[pos].id == req.entry_id) begin
                        rows[pos].offset      = reloc;
                        rows[pos].size        = req.entry_size;
                        rows[pos].packed_size = req.entry_packed_size;
                        res.replaced = 1'b1;
                        hit = 1'b1;
                        replace_hits++;
                    end else if (count >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (k = count; k > pos; k--) rows[k] = rows[k-1];
                        rows[pos] = row;
                        count++;
                        hit = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    lo = 0;
                    hi = count - 1;
                    while (!hit && lo <= hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (rows[mid].id == req.entry_id) begin
                            pos = mid;
                            hit = 1'b1;
                        end else if (req.entry_id < rows[mid].id) begin
                            hi = mid - 1;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    if (!hit) res.status = ST_NOT_FOUND;
                end
                OP_READ: begin
                    if (req.read_position >= count) begin
                        res.status = ST_BAD_POS;
                    end else begin
                        pos = req.read_position;
                        hit = 1'b1;
                    end
                end
            endcase
            if (hit) begin
                res.hit_position    = pos[9:0];
                res.out_id          = rows[pos].id;
                res.out_offset      = rows[pos].offset;
                res.out_size        = rows[pos].size;
                res.out_packed_size = rows[pos].packed_size;
            end
            res.entry_count = count[10:0];
            status_hits[res.status]++;
            return res;
        endfunction

        function void note(t_in req);
            expected_results.push_back(apply_table_op(req));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check(t_out got);
            t_out want;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transaction with no operation outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("replaced", want.replaced, got.replaced);
            compare_field("hit_position", want.hit_position, got.hit_position);
            compare_field("out_id", want.out_id, got.out_id);
            compare_field("out_offset", want.out_offset, got.out_offset);
            compare_field("out_size", want.out_size, got.out_size);
            compare_field("out_packed_size", want.out_packed_size, got.out_packed_size);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;

    bit                    stalls_on      = 1'b1;
    int                    out_stall_left = 0;
    merge_table_scoreboard sb;

    sorted_index_merge_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            out_stall_left = $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) sb.check(o_out_data);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send(t_in req);
        @(negedge i_clk);
        if (stalls_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note(req);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_relocation(logic [31:0] base, logic [15:0] hdr);
        drain();
        cfg_write(CFG_RELOCATION_BASE, base);
        cfg_write(CFG_HEADER_BYTES, {16'($urandom), hdr});
    endtask

    function automatic t_in make_req(logic [1:0] op, logic [31:0] id);
        t_in req;
        req.operation         = op;
        req.entry_id          = id;
        req.entry_offset      = $urandom;
        req.entry_size        = $urandom;
        req.entry_packed_size = $urandom;
        req.read_position     = 10'($urandom);
        return req;
    endfunction

    // Mostly ids already in the table or next to one, so merges replace and lookups hit.
    function automatic logic [31:0] pick_id();
        logic [31:0] known;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (sb.count == 0 || roll < 25) return $urandom;
        known = sb.rows[$urandom_range(0, sb.count - 1)].id;
        if (roll < 75) return known;
        if (roll < 85) return known + 1;
        if (roll < 92) return known - 1;
        return roll[0] ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    function automatic t_in random_op();
        t_in         req;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            req = make_req(OP_APPEND, pick_id());
            if (sb.count > 0 && roll < 9)
                req.entry_id = sb.rows[sb.count - 1].id + $urandom_range(1, 1000);
        end else if (roll < 55) begin
            req = make_req(OP_MERGE, pick_id());
        end else if (roll < 80) begin
            req = make_req(OP_LOOKUP, pick_id());
        end else begin
            req = make_req(OP_READ, pick_id());
            if (sb.count > 0 && roll < 95)
                req.read_position = 10'($urandom_range(0, sb.count - 1));
        end
        return req;
    endfunction

    initial begin
        t_in         req;
        logic [31:0] fresh_id;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then ordered inserts, a replace, and appends that break the order
        send(t_in'{OP_LOOKUP, 32'd5, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_READ, 32'hFFFF_FFFF, '1, '1, '1, 10'd1023});
        send(t_in'{OP_MERGE, 32'd100, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_MERGE, 32'd0, '1, '1, '1, 10'd1023});
        send(t_in'{OP_MERGE, 32'hFFFF_FFFF, 32'h1234, 32'h10, 32'h8, 10'd5});
        send(t_in'{OP_MERGE, 32'd100, 32'h55AA, 32'h200, 32'h100, 10'd0});
        send(t_in'{OP_MERGE, 32'd50, 32'h77, 32'h3, 32'h2, 10'd0});
        send(t_in'{OP_APPEND, 32'd7, '1, 32'd0, '1, 10'd0});
        send(t_in'{OP_APPEND, 32'hFFFF_FFFF, '1, '1, '1, 10'd1023});
        send(t_in'{OP_LOOKUP, 32'd100, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_LOOKUP, 32'd7, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_LOOKUP, 32'd12345, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd6});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd7});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd1023});

        // relocation wrapping past 2^32 and below zero
        set_relocation(32'hFFFF_FFFF, 16'h0000);
        send(t_in'{OP_MERGE, 32'd200, 32'd10, 32'd1, 32'd1, 10'd0});
        set_relocation(32'h0, 16'hFFFF);
        cfg_write(CFG_UNMAPPED, $urandom);
        send(t_in'{OP_MERGE, 32'd300, 32'd0, 32'd4, 32'd4, 10'd0});
        send(t_in'{OP_MERGE, 32'd50, 32'd5, 32'd9, 32'd9, 10'd0});
        send(t_in'{OP_LOOKUP, 32'd300, 32'd0, 32'd0, 32'd0, 10'd0});
        send(t_in'{OP_READ, 32'd0, 32'd0, 32'd0, 32'd0, 10'd2});

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_relocation($urandom, 16'($urandom));
                1: set_relocation(32'hFFFF_FFFF, 16'h0000);
                2: set_relocation(32'h0, 16'hFFFF);
                default: begin
                    set_relocation($urandom, 16'($urandom));
                    cfg_write(CFG_UNMAPPED, $urandom);
                end
            endcase
            repeat (PHASE_ITEMS) send(random_op());
        end

        // fill to capacity, mostly ascending appends
        while (sb.count < DEPTH) begin
            if (sb.count >= DEPTH - 128) stalls_on = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                send(random_op());
            end else begin
                req = make_req(OP_APPEND, sb.rows[sb.count - 1].id + $urandom_range(1, 1000));
                send(req);
            end
        end

        // full table: rejected inserts, a replace that still succeeds, edge reads
        send(make_req(OP_APPEND, pick_id()));
        do fresh_id = $urandom; while (sb.holds_id(fresh_id));
        send(make_req(OP_MERGE, fresh_id));
        send(make_req(OP_MERGE, sb.rows[0].id));
        send(make_req(OP_LOOKUP, sb.rows[DEPTH / 2].id));
        req = make_req(OP_READ, $urandom);
        req.read_position = 10'(DEPTH - 1);
        send(req);
        req.read_position = 10'd0;
        send(req);
        repeat (20) send(random_op());

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d appends, %0d merges (%0d replaced), %0d lookups, %0d reads",
                 sb.results_seen, sb.op_hits[OP_APPEND], sb.op_hits[OP_MERGE], sb.replace_hits,
                 sb.op_hits[OP_LOOKUP], sb.op_hits[OP_READ]);
        $display("Statuses: ok %0d, not found %0d, full %0d, bad position %0d; final entries %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_BAD_POS], sb.count);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/sim_pkg.sv
sv/sim_table_mem.sv
sv/sim_ctrl.sv
sv/sorted_index_merge_table.sv
sim/sorted_index_merge_table_tb.sv
